### rtl/core/hgz_pkg.sv
// shared types, character codes and match tables for the http header gzip scanner
`timescale 1ns / 1ps

package hgz_pkg;

  // byte position counter width, saturating
  localparam int unsigned PositionBits = 16;
  localparam int unsigned OffsetBits   = 16;
  localparam logic [OffsetBits-1:0] OffsetMax = '1;

  // parse phase codes
  localparam logic [1:0] PhaseStatus = 2'd0;
  localparam logic [1:0] PhaseHeader = 2'd1;
  localparam logic [1:0] PhaseDone   = 2'd2;

  // key matcher codes
  localparam logic [1:0] KeyMatching  = 2'd0;
  localparam logic [1:0] KeyMismatch  = 2'd1;
  localparam logic [1:0] KeyGoodColon = 2'd2;
  localparam logic [1:0] KeyBadColon  = 2'd3;

  localparam logic [4:0] KeyLen = 5'd16;
  localparam logic [2:0] GzLen  = 3'd4;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChG     = 8'h67;

  // per line parse state
  typedef struct packed {
    logic       nonempty;
    logic [4:0] key_idx;
    logic [1:0] key_st;
    logic       after_colon;
    logic [2:0] gz_idx;
    logic       has_gz;
  } line_state_t;

  localparam line_state_t LineClear = '{
    nonempty:    1'b0,
    key_idx:     5'd0,
    key_st:      KeyMatching,
    after_colon: 1'b0,
    gz_idx:      3'd0,
    has_gz:      1'b0
  };

  // "Content-Encoding"
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h6F;
      4'd2:    c = 8'h6E;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6E;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2D;
      4'd8:    c = 8'h45;
      4'd9:    c = 8'h6E;
      4'd10:   c = 8'h63;
      4'd11:   c = 8'h6F;
      4'd12:   c = 8'h64;
      4'd13:   c = 8'h69;
      4'd14:   c = 8'h6E;
      default: c = 8'h67;
    endcase
    return c;
  endfunction

  // "gzip"
  function automatic logic [7:0] gz_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h67;
      2'd1:    c = 8'h7A;
      2'd2:    c = 8'h69;
      default: c = 8'h70;
    endcase
    return c;
  endfunction

  // clamp a position to the offset width
  function automatic logic [OffsetBits-1:0] sat_offset(input logic [PositionBits-1:0] p);
    logic [PositionBits+OffsetBits-1:0] wide;
    logic [PositionBits+OffsetBits-1:0] lim;
    wide = {{OffsetBits{1'b0}}, p};
    lim  = {{PositionBits{1'b0}}, OffsetMax};
    if (wide > lim) begin
      return OffsetMax;
    end
    return wide[OffsetBits-1:0];
  endfunction

endpackage

### rtl/core/http_header_gzip_scanner.sv
// top level of the http header gzip scanner: byte parser state and result register
`timescale 1ns / 1ps

// http header gzip scanner. takes the bytes of one http message buffer, one word
// per cycle, and on the word flagged last_byte_i gives one result word: the offset
// where the body starts (end of the last complete header line, saturating at
// 65535) and whether a complete Content-Encoding line held gzip. first_byte_i
// clears the parse state before its byte is taken. every byte is parsed in the
// cycle it is accepted, so the block takes one word per cycle with no gaps; the
// result register holds one pending result, and input stalls only when that
// result has not been taken. a result is registered and is valid in the cycle after its last byte.
module http_header_gzip_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] body_offset_o,
  output logic        is_gzipped_o
);
  import hgz_pkg::*;

  // parse state
  logic [1:0]              phase_q, phase_d;
  logic                    cr_q, cr_d;
  logic [PositionBits-1:0] pos_q, pos_d;
  logic [PositionBits-1:0] commit_q, commit_d;
  logic                    found_q, found_d;
  line_state_t             line_q, line_d;

  // state after an optional clear on first byte
  logic [1:0]              phase_b;
  logic                    cr_b;
  logic [PositionBits-1:0] pos_b;
  logic [PositionBits-1:0] commit_b;
  logic                    found_b;
  line_state_t             line_b;

  // two chained line steps: a held cr turning into a line byte, then this byte
  line_state_t             line_cr, line_in1, line_byte;
  logic [PositionBits-1:0] pos_inc;

  // result register
  logic                    out_valid_q, out_valid_d;
  logic [OffsetBits-1:0]   offset_q;
  logic                    gz_q;

  logic in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    if (first_byte_i) begin
      phase_b  = PhaseStatus;
      cr_b     = 1'b0;
      pos_b    = '0;
      commit_b = '0;
      found_b  = 1'b0;
      line_b   = LineClear;
    end else begin
      phase_b  = phase_q;
      cr_b     = cr_q;
      pos_b    = pos_q;
      commit_b = commit_q;
      found_b  = found_q;
      line_b   = line_q;
    end
  end

  assign pos_inc = (pos_b == '1) ? pos_b : pos_b + 1'b1;

  hgz_line u_line_cr (
    .line_i (line_b),
    .byte_i (ChCr),
    .line_o (line_cr)
  );

  assign line_in1 = cr_b ? line_cr : line_b;

  hgz_line u_line_byte (
    .line_i (line_in1),
    .byte_i (data_byte_i),
    .line_o (line_byte)
  );

  // per byte parse step
  always_comb begin
    phase_d  = phase_b;
    cr_d     = cr_b;
    pos_d    = pos_b;
    commit_d = commit_b;
    found_d  = found_b;
    line_d   = line_b;
    if (phase_b == PhaseStatus || phase_b == PhaseHeader) begin
      if (data_byte_i == ChNul) begin
        // nul ends the data
        phase_d = PhaseDone;
      end else begin
        pos_d = pos_inc;
        if (phase_b == PhaseStatus) begin
          commit_d = pos_inc;
          if (cr_b && data_byte_i == ChLf) begin
            cr_d    = 1'b0;
            phase_d = PhaseHeader;
            line_d  = LineClear;
          end else begin
            cr_d = (data_byte_i == ChCr);
          end
        end else if (cr_b && data_byte_i == ChLf) begin
          // line complete: empty or colonless line stops the scan
          cr_d     = 1'b0;
          commit_d = pos_inc;
          line_d   = LineClear;
          if (!line_b.nonempty || line_b.key_st == KeyMatching ||
              line_b.key_st == KeyMismatch) begin
            phase_d = PhaseDone;
          end else if (line_b.key_st == KeyGoodColon && line_b.has_gz) begin
            found_d = 1'b1;
          end
        end else begin
          cr_d   = (data_byte_i == ChCr);
          line_d = (data_byte_i == ChCr) ? line_in1 : line_byte;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire && last_byte_i) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhaseStatus;
      cr_q        <= 1'b0;
      pos_q       <= '0;
      commit_q    <= '0;
      found_q     <= 1'b0;
      line_q      <= LineClear;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        phase_q  <= phase_d;
        cr_q     <= cr_d;
        pos_q    <= pos_d;
        commit_q <= commit_d;
        found_q  <= found_d;
        line_q   <= line_d;
      end
    end
  end

  // result payload, loaded on the last word of a buffer
  always_ff @(posedge clk_i) begin
    if (in_fire && last_byte_i) begin
      offset_q <= sat_offset(commit_d);
      gz_q     <= found_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign body_offset_o = offset_q;
  assign is_gzipped_o  = gz_q;

endmodule

### rtl/core/hgz_line.sv
// one header line byte step: key match, colon tracking and gzip search
`timescale 1ns / 1ps

module hgz_line (
  input  hgz_pkg::line_state_t line_i,
  input  logic [7:0]           byte_i,
  output hgz_pkg::line_state_t line_o
);
  import hgz_pkg::*;

  logic [2:0] gz_next;

  always_comb begin
    line_o          = line_i;
    line_o.nonempty = 1'b1;
    gz_next         = line_i.gz_idx;
    unique case (line_i.key_st)
      KeyMatching: begin
        if (byte_i == ChColon) begin
          line_o.key_st = (line_i.key_idx == KeyLen) ? KeyGoodColon : KeyBadColon;
        end else if (line_i.key_idx != KeyLen && byte_i == key_char(line_i.key_idx[3:0])) begin
          line_o.key_idx = line_i.key_idx + 5'd1;
        end else begin
          line_o.key_st = KeyMismatch;
        end
      end
      KeyMismatch: begin
        if (byte_i == ChColon) begin
          line_o.key_st = KeyBadColon;
        end
      end
      default: begin
        // first byte after the colon is skipped
        if (!line_i.after_colon) begin
          line_o.after_colon = 1'b1;
        end else if (line_i.key_st == KeyGoodColon && !line_i.has_gz) begin
          if (line_i.gz_idx != GzLen && byte_i == gz_char(line_i.gz_idx[1:0])) begin
            gz_next = line_i.gz_idx + 3'd1;
          end else begin
            gz_next = (byte_i == ChG) ? 3'd1 : 3'd0;
          end
          line_o.gz_idx = gz_next;
          if (gz_next == GzLen) begin
            line_o.has_gz = 1'b1;
          end
        end
      end
    endcase
  end

endmodule

### tb/sv/hgz_checker.sv
// checker for the http header gzip scanner: watches both channels, predicts and compares
`timescale 1ns / 1ps

module hgz_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] body_offset_i,
  input  logic        is_gzipped_i,
  output int          error_count_o,
  output int          waiting_o,
  output int          checked_o
);
  import hgz_pkg::*;

  localparam logic [127:0] KeyText = "Content-Encoding";
  localparam logic [31:0]  GzText  = "gzip";

  typedef struct packed {
    logic [15:0] offset;
    logic        gzipped;
  } scan_result_t;

  scan_result_t expected_q[$];
  int errors;
  int checked;

  // predicted scanner state
  logic [1:0]              phase;
  logic                    cr_pend;
  logic [PositionBits-1:0] pos;
  logic [PositionBits-1:0] commit;
  logic [15:0]             line_len;
  logic [4:0]              key_idx;
  logic [1:0]              key_st;
  logic                    past_colon;
  logic [2:0]              gz_idx;
  logic                    line_gz;
  logic                    gz_found;

  function automatic void clear_line();
    line_len   = '0;
    key_idx    = '0;
    key_st     = KeyMatching;
    past_colon = 1'b0;
    gz_idx     = '0;
    line_gz    = 1'b0;
  endfunction

  function automatic void clear_scan();
    phase    = PhaseStatus;
    cr_pend  = 1'b0;
    pos      = '0;
    commit   = '0;
    gz_found = 1'b0;
    clear_line();
  endfunction

  function automatic void line_byte(input logic [7:0] b);
    if (line_len != 16'hFFFF) line_len++;
    if (key_st == KeyMatching) begin
      if (b == ChColon) key_st = (key_idx == KeyLen) ? KeyGoodColon : KeyBadColon;
      else if (key_idx < KeyLen && b == KeyText[127 - 8*key_idx -: 8]) key_idx++;
      else key_st = KeyMismatch;
    end else if (key_st == KeyMismatch) begin
      if (b == ChColon) key_st = KeyBadColon;
    end else if (!past_colon) begin
      // the byte right after the colon is never part of the value
      past_colon = 1'b1;
    end else if (key_st == KeyGoodColon && !line_gz) begin
      if (gz_idx < GzLen && b == GzText[31 - 8*gz_idx -: 8]) gz_idx++;
      else gz_idx = (b == ChG) ? 3'd1 : 3'd0;
      if (gz_idx == GzLen) line_gz = 1'b1;
    end
  endfunction

  function automatic void close_line();
    commit = pos;
    if (line_len == 0 || key_st == KeyMatching || key_st == KeyMismatch) phase = PhaseDone;
    else if (key_st == KeyGoodColon && line_gz) gz_found = 1'b1;
    clear_line();
  endfunction

  function automatic void scan_byte(input logic [7:0] b);
    if (phase >= PhaseDone) return;
    if (b == ChNul) begin
      phase = PhaseDone;
      return;
    end
    if (pos != '1) pos++;
    if (phase == PhaseStatus) begin
      commit = pos;
      if (cr_pend && b == ChLf) begin
        cr_pend = 1'b0;
        phase   = PhaseHeader;
        clear_line();
      end else begin
        cr_pend = (b == ChCr);
      end
      return;
    end
    if (cr_pend) begin
      cr_pend = 1'b0;
      if (b == ChLf) begin
        close_line();
        return;
      end
      line_byte(ChCr);
    end
    if (b == ChCr) cr_pend = 1'b1;
    else line_byte(b);
  endfunction

  function automatic scan_result_t current_result();
    scan_result_t r;
    logic [63:0] wide;
    wide = 64'(commit);
    r.offset  = (wide > 64'hFFFF) ? 16'hFFFF : wide[15:0];
    r.gzipped = gz_found;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scan_result_t want;
    if (!rst_ni) begin
      clear_scan();
      expected_q.delete();
      errors = 0;
      checked = 0;
      error_count_o <= 0;
      waiting_o <= 0;
      checked_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word: expected none, got offset %0d gzip %0b",
                   $time, body_offset_i, is_gzipped_i);
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (body_offset_i !== want.offset) begin
            errors++;
            $display("%0t: body offset mismatch: expected %0d, got %0d",
                     $time, want.offset, body_offset_i);
          end
          if (is_gzipped_i !== want.gzipped) begin
            errors++;
            $display("%0t: gzip flag mismatch: expected %0b, got %0b",
                     $time, want.gzipped, is_gzipped_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (first_byte_i) clear_scan();
        scan_byte(data_byte_i);
        if (last_byte_i) expected_q.push_back(current_result());
      end
      error_count_o <= errors;
      waiting_o <= expected_q.size();
      checked_o <= checked;
    end
  end

endmodule

### tb/sv/tb_top.sv
// testbench top for the http header gzip scanner: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps

module tb_top;
  import hgz_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        first_byte_i = 1'b0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] body_offset_o;
  logic        is_gzipped_o;

  int error_count;
  int waiting;
  int checked;

  // pacing knobs, changed per phase by the stimulus process
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int buffers_sent = 0;
  int bytes_sent = 0;

  // bytes of the message being assembled
  logic [7:0] msg_q[$];

  always #1 clk_i = ~clk_i;

  http_header_gzip_scanner u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .body_offset_o(body_offset_o),
    .is_gzipped_o (is_gzipped_o)
  );

  hgz_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .body_offset_i(body_offset_o),
    .is_gzipped_i (is_gzipped_o),
    .error_count_o(error_count),
    .waiting_o    (waiting),
    .checked_o    (checked)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // generous cap, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("http_header_gzip_scanner test failed");
    $finish;
  end

  function automatic void add_byte(input logic [7:0] b);
    msg_q.push_back(b);
  endfunction

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
  endfunction

  // printable text biased towards the letters of gzip, sometimes high bytes, never a colon
  function automatic logic [7:0] text_char();
    string g = "gzip";
    logic [7:0] c;
    case ($urandom_range(9, 0))
      0, 1:    c = g[$urandom_range(3, 0)];
      2:       c = 8'h80 + 8'($urandom_range(127, 0));
      default: c = 8'($urandom_range(8'h7E, 8'h20));
    endcase
    if (c == ChColon) c = 8'h2D;
    return c;
  endfunction

  function automatic void add_text(input int n);
    repeat (n) msg_q.push_back(text_char());
  endfunction

  // one header line body, without its line end
  function automatic void add_line();
    string k;
    int j;
    k = "Content-Encoding";
    case ($urandom_range(9, 0))
      0, 1, 2: begin
        add_str("Content-Encoding:");
        add_byte(($urandom_range(3, 0) == 0) ? text_char() : 8'h20);
        add_text($urandom_range(3, 0));
        case ($urandom_range(3, 0))
          0: add_str("gzip");
          1: add_str("ggzip");
          2: add_str("gzgzip");
          default: add_str("gzi");
        endcase
        add_text($urandom_range(3, 0));
      end
      3: begin
        // near miss on the key: one letter off, cut short or running on
        j = $urandom_range(15, 0);
        case ($urandom_range(2, 0))
          0: k[j] = k[j] + 8'd1;
          1: k = k.substr(0, (j > 14) ? 14 : j);
          default: k = {k, "s"};
        endcase
        add_str({k, ": gzip"});
      end
      4: begin
        // value too short to hold anything
        add_str("Content-Encoding:");
        if ($urandom_range(1, 0)) add_str("g");
      end
      5: begin
        add_text($urandom_range(5, 1));
        add_str(":");
        add_text($urandom_range(6, 0));
      end
      6: begin
        // lone cr inside the value
        add_str("Content-Encoding: ");
        add_text($urandom_range(2, 0));
        add_byte(ChCr);
        if ($urandom_range(1, 0)) add_str("gzip");
        add_text($urandom_range(2, 0));
      end
      7: add_text($urandom_range(6, 1));
      8: begin
        add_str(":");
        add_text($urandom_range(4, 0));
        if ($urandom_range(1, 0)) add_str("gzip");
      end
      default: begin
        if ($urandom_range(1, 0)) add_str("Content-Encoding:gzip");
        else add_str("Content-Encoding::gzip");
      end
    endcase
  endfunction

  // message with random content, mostly well-formed; returns the bytes that matter to the parse
  function automatic int build_message();
    int live;
    msg_q.delete();
    add_text($urandom_range(8, 0));
    if ($urandom_range(4, 0) == 0) begin
      add_byte(ChCr);
      add_text($urandom_range(3, 0));
    end
    if ($urandom_range(9, 0) != 0) add_str("\r\n");
    repeat ($urandom_range(4, 0)) begin
      add_line();
      add_str("\r\n");
    end
    case ($urandom_range(19, 0))
      14, 15, 16: add_line();
      17, 18: add_byte(ChNul);
      19: ;
      default: add_str("\r\n");
    endcase
    live = msg_q.size();
    add_text($urandom_range(5, 0));
    return live;
  endfunction

  // one word through the input channel, with optional idle cycles ahead of it
  task automatic put_word(input logic [7:0] b, input logic f, input logic l);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    first_byte_i <= f;
    last_byte_i  <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_buffer(input bit mark_first, input bit mark_last);
    int n;
    n = msg_q.size();
    for (int i = 0; i < n; i++) begin
      put_word(msg_q[i], mark_first && i == 0, mark_last && i == n - 1);
    end
    if (mark_last && n > 0) buffers_sent++;
    msg_q.delete();
  endtask

  task automatic send_text(input string s, input bit mark_first, input bit mark_last);
    add_str(s);
    send_buffer(mark_first, mark_last);
  endtask

  // hold the sender until every expected result word is back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (waiting != 0);
  endtask

  initial begin
    int send_tab[4];
    int recv_tab[4];
    int phase_bytes;
    int phase_results;
    int live;
    send_tab = '{0, 84, 0, 20};
    recv_tab = '{0, 0, 84, 20};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes of the byte, each named corner of the parse
    add_byte(8'hFF);
    send_buffer(1, 1);
    add_byte(ChNul);
    send_buffer(1, 1);
    send_text("HTTP/1.1 200 OK", 1, 1);
    send_text("S\r\nContent-Encoding: gzip\r\n\r\nbody", 1, 1);
    send_text("S\r\nX:v", 1, 1);
    add_str("S\rT\r\nA:\r");
    add_byte(8'hFF);
    add_str("\r\n\r\n");
    send_buffer(1, 1);
    add_str("S\r\n");
    add_byte(ChNul);
    add_str("Content-Encoding: gzip\r\n\r\n");
    send_buffer(1, 1);
    send_text("S\r\nnocolon\r\nContent-Encoding: gzip\r\n\r\n", 1, 1);
    send_text("S\r\nContent-Encoding:\r\nContent-Encoding:g\r\n\r\n", 1, 1);
    // a buffer split over two runs with no first mark on the second
    send_text("S\r\nContent-Encoding: gzip\r\n", 1, 0);
    send_text("\r\n", 0, 1);
    drain();

    // random part: four pacing mixes, mostly well-formed messages
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_tab[p];
      recv_stall_pct = recv_tab[p];
      phase_bytes = 0;
      phase_results = 0;
      while (phase_bytes < 430 || phase_results < 12) begin
        case ($urandom_range(19, 0))
          16, 17: begin
            // noise burst with loose first and last marks
            repeat ($urandom_range(8, 1)) begin
              add_byte(8'($urandom_range(255, 0)));
              put_word(msg_q.pop_back(), ($urandom_range(7, 0) == 0),
                       ($urandom_range(7, 0) == 0));
              phase_bytes++;
            end
          end
          18: begin
            phase_bytes += build_message();
            send_buffer(0, 1);
            phase_results++;
          end
          19: begin
            phase_bytes += build_message();
            send_buffer(1, 0);
          end
          default: begin
            live = build_message();
            phase_bytes += live;
            send_buffer(1, 1);
            phase_results++;
          end
        endcase
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    $display("covered %0d buffers over %0d bytes, directed parse corners and random messages,",
             buffers_sent, bytes_sent);
    $display("under four idle and stall mixes; %0d result words compared", checked);
    if (error_count == 0 && waiting == 0) begin
      $display("http_header_gzip_scanner test passed");
    end else begin
      $display("http_header_gzip_scanner test failed");
    end
    $finish;
  end

endmodule
